// File: design/rhrs_pkg.sv
package rhrs_pkg;

    // Number of slots in the ring. The position and count fields are sized from it.
    localparam int CAPACITY = 16;
    localparam int HASH_W   = 64;
    localparam int CMD_W    = 2;
    localparam int POS_W    = $clog2(CAPACITY + 1);

    // Command codes carried in the command field.
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // An empty slot holds the all-ones pattern.
    localparam logic [HASH_W-1:0] EMPTY_SLOT = '1;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [HASH_W-1:0] hash;
    } cmd_t;

    typedef struct packed {
        logic found;
        pos_t removed_count;
        pos_t write_position;
    } rsp_t;

endpackage

// File: design/recent_hash_ring_set_core.sv
// Channel  Direction  Handshake               Payload
// cmd      in         cmd_valid / cmd_stall   rhrs_pkg::cmd_t (command, hash)
// rsp      out        rsp_valid / rsp_stall   rhrs_pkg::rsp_t (found, removed_count,
//                                             write_position)
//
// After reset the block writes the empty marker into every slot; cmd_stall
// stays high during that clearing pass.
// An add, or an unused command code, passes through the done state to the result register.
// A query reads one slot per cycle from the entry memory.
// A remove scans the same way, and each deletion adds a shift pass that moves one
// entry per cycle through the single read and write port, then blanks the last slot
// and scans again from the same slot. One command is in work at a time.
// A result waiting on rsp_stall does not stop the next command from being taken.
module recent_hash_ring_set_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  rhrs_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output rhrs_pkg::rsp_t  rsp
);

    localparam int CAPACITY = rhrs_pkg::CAPACITY;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SCAN_RD  = 3'd2;
    localparam logic [2:0] ST_SCAN_CMP = 3'd3;
    localparam logic [2:0] ST_SH_WR    = 3'd4;
    localparam logic [2:0] ST_SH_LAST  = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] p_reg, p_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic          found_reg, found_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rhrs_pkg::rsp_t rsp_reg, rsp_next;

    logic [rhrs_pkg::CMD_W-1:0]  cmd_code_reg;
    logic [rhrs_pkg::HASH_W-1:0] hash_reg;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [rhrs_pkg::HASH_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [rhrs_pkg::HASH_W-1:0] ram_rdata;

    logic [CW-1:0] end_pos;
    logic [AW-1:0] last;
    logic [AW-1:0] slot_nx;
    logic [AW-1:0] p_nx;
    logic [AW-1:0] p_nx2;
    logic [AW-1:0] add_addr;
    logic [CW-1:0] count_inc;
    logic          cmd_xfer;
    logic          rsp_free;
    logic          match;

    rhrs_ram #(
        .WIDTH (rhrs_pkg::HASH_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // A write position of zero counts as a full ring while deleting, so the
    // slot that gets blanked is always the one just before the end position.
    assign end_pos = (wp_reg == '0) ? CW'(CAPACITY) : wp_reg;
    assign last    = AW'(end_pos - CW'(1));

    // Successor of a slot around the ring.
    assign slot_nx = (slot_reg == AW'(CAPACITY - 1)) ? '0 : slot_reg + AW'(1);
    assign p_nx    = (p_reg == AW'(CAPACITY - 1)) ? '0 : p_reg + AW'(1);
    assign p_nx2   = (p_nx == AW'(CAPACITY - 1)) ? '0 : p_nx + AW'(1);

    // An add at a full position wraps to slot zero first.
    assign add_addr = (wp_reg >= CW'(CAPACITY)) ? '0 : AW'(wp_reg);

    assign count_inc = count_reg + CW'(1);
    assign match     = (ram_rdata == hash_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        slot_next      = slot_reg;
        p_next         = p_reg;
        count_next     = count_reg;
        wp_next        = wp_reg;
        found_next     = found_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = p_reg;
        ram_wdata      = rhrs_pkg::EMPTY_SLOT;
        ram_raddr      = slot_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == AW'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    found_next = 1'b0;
                    count_next = '0;
                    slot_next  = '0;
                    case (cmd.command)
                        rhrs_pkg::CMD_ADD:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = add_addr;
                            ram_wdata  = cmd.hash;
                            wp_next    = CW'(add_addr) + CW'(1);
                            state_next = ST_DONE;
                        end
                        rhrs_pkg::CMD_QUERY,
                        rhrs_pkg::CMD_REMOVE:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN_RD:
            begin
                ram_raddr  = slot_reg;
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                // The successor is read ahead: it is either the next slot to
                // compare or the first entry to move down on a deletion.
                ram_raddr = slot_nx;
                if (match)
                begin
                    if (cmd_code_reg == rhrs_pkg::CMD_QUERY)
                    begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        p_next     = slot_reg;
                        state_next = (slot_reg == last) ? ST_SH_LAST : ST_SH_WR;
                    end
                end
                else if (slot_reg == AW'(CAPACITY - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    slot_next = slot_nx;
                end
            end

            ST_SH_WR:
            begin
                // Move the successor's entry down one place and fetch the next.
                ram_we     = 1'b1;
                ram_waddr  = p_reg;
                ram_wdata  = ram_rdata;
                ram_raddr  = p_nx2;
                p_next     = p_nx;
                if (p_nx == last)
                begin
                    state_next = ST_SH_LAST;
                end
            end

            ST_SH_LAST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = last;
                ram_wdata  = rhrs_pkg::EMPTY_SLOT;
                wp_next    = CW'(last);
                count_next = count_inc;
                // The same slot is compared again, since a new entry moved in.
                if (count_inc == CW'(CAPACITY))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end

            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next.found          = found_reg;
                    rsp_next.removed_count  = rhrs_pkg::pos_t'(count_reg);
                    rsp_next.write_position = rhrs_pkg::pos_t'(wp_reg);
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            slot_reg      <= '0;
            p_reg         <= '0;
            count_reg     <= '0;
            wp_reg        <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            slot_reg      <= slot_next;
            p_reg         <= p_next;
            count_reg     <= count_next;
            wp_reg        <= wp_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd_xfer)
        begin
            cmd_code_reg <= cmd.command;
            hash_reg     <= cmd.hash;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> state_reg != ST_IDLE)
        else $error("block idle right after taking a command");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("response raised outside the done state");

    a_shift_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SH_WR && p_nx != last) |-> ram_waddr != ram_raddr)
        else $error("shift pass reads the slot it writes");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SH_LAST |-> count_reg < CW'(CAPACITY))
        else $error("deletion count passed the ring capacity");
`endif

endmodule

// File: design/rhrs_ram.sv
module rhrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
